// ----- sv/rmct_pkg.sv -----
`default_nettype none
package rmct_pkg;

	localparam int COEFF_WIDTH_DEF = 16;
	localparam int RUN_W = 8;
	localparam int RES_W = 18;
	localparam int CNT_W = 5;
	localparam int SYM_W = 8;
	localparam int MAG_RES_W = 10;
	localparam int MAG_CLIP_ABOVE = 2047;
	localparam logic [RUN_W-1:0] RUN_SPLIT_LEN = 8'd255;

	localparam logic [7:0] RUN_BASE [10] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4,
		8'd8, 8'd16, 8'd32, 8'd64, 8'd128};
	localparam logic [2:0] RUN_XBITS [10] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd2,
		3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
	localparam logic [10:0] MAG_BASE [16] = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd4,
		11'd5, 11'd6, 11'd7, 11'd8, 11'd16, 11'd32, 11'd64, 11'd128, 11'd256,
		11'd512, 11'd1024};
	localparam logic [3:0] MAG_XBITS [16] = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		4'd0, 4'd0, 4'd0, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10};

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic [RES_W-1:0] residual_value;
		logic [CNT_W-1:0] residual_count;
		logic             magnitude_clipped;
		logic             last;
	} token_t;

	typedef struct packed {
		logic [1:0] n;
		token_t     tok0;
		token_t     tok1;
	} tok_pair_t;

	function automatic logic [3:0] run_class(input logic [RUN_W-1:0] run);
		logic [3:0] c;
		c = 4'd0;
		for (int i = 1; i < 10; i++) begin
			if (run >= RUN_BASE[i]) begin
				c = 4'(i);
			end
		end
		return c;
	endfunction

	function automatic logic [6:0] run_offset(input logic [RUN_W-1:0] run,
		input logic [3:0] rc);
		logic [7:0] d;
		logic [7:0] m;
		d = run - RUN_BASE[rc];
		m = (8'd1 << RUN_XBITS[rc]) - 8'd1;
		return 7'(d & m);
	endfunction

	function automatic token_t run_only_token(input logic [RUN_W-1:0] run);
		token_t t;
		logic [3:0] rc;
		rc = run_class(run);
		t.symbol = {rc, 4'd0};
		t.residual_value = RES_W'(run_offset(run, rc));
		t.residual_count = CNT_W'(RUN_XBITS[rc]);
		t.magnitude_clipped = 1'b0;
		t.last = 1'b0;
		return t;
	endfunction

endpackage
`default_nettype wire

// ----- sv/rmct_encode.sv -----
`default_nettype none
module rmct_encode #(
	parameter int COEFF_WIDTH = rmct_pkg::COEFF_WIDTH_DEF
) (
	input  wire logic [COEFF_WIDTH-1:0]     coefficient,
	input  wire logic                       row_end,
	input  wire logic [rmct_pkg::RUN_W-1:0] zero_run,
	output rmct_pkg::tok_pair_t             pair,
	output logic [rmct_pkg::RUN_W-1:0]      zero_run_next
);

	localparam int MW = (COEFF_WIDTH > 12) ? COEFF_WIDTH : 12;

	logic                        is_zero;
	logic                        neg;
	logic [COEFF_WIDTH-1:0]      mag;
	logic [MW-1:0]               mag_ext;
	logic [MW-1:0]               mdiff;
	logic [3:0]                  mc;
	logic [3:0]                  rc;
	logic [3:0]                  mb;
	logic [2:0]                  rb;
	logic [rmct_pkg::MAG_RES_W-1:0] mr;
	logic [6:0]                  rr;
	logic [rmct_pkg::RUN_W:0]    r1;
	logic                        long_run;
	logic [rmct_pkg::RUN_W-1:0]  r2;
	rmct_pkg::token_t            joint;
	rmct_pkg::token_t            long_tok;
	rmct_pkg::token_t            flush_tok;

	always_comb begin
		is_zero = (coefficient == '0);
		neg = coefficient[COEFF_WIDTH-1];
		mag = neg ? (~coefficient + COEFF_WIDTH'(1)) : coefficient;
		mag_ext = MW'(mag);
		mc = 4'd0;
		for (int i = 1; i < 16; i++) begin
			if (mag_ext >= MW'(rmct_pkg::MAG_BASE[i])) begin
				mc = 4'(i);
			end
		end
		mb = rmct_pkg::MAG_XBITS[mc];
		mdiff = mag_ext - MW'(rmct_pkg::MAG_BASE[mc]);
		mr = mdiff[rmct_pkg::MAG_RES_W-1:0]
			& ((rmct_pkg::MAG_RES_W'(1) << mb) - rmct_pkg::MAG_RES_W'(1));

		rc = rmct_pkg::run_class(zero_run);
		rb = rmct_pkg::RUN_XBITS[rc];
		rr = rmct_pkg::run_offset(zero_run, rc);

		joint.symbol = {rc, mc};
		joint.residual_value = rmct_pkg::RES_W'(rr)
			| (rmct_pkg::RES_W'(mr) << rb)
			| (rmct_pkg::RES_W'(neg) << (5'(rb) + 5'(mb)));
		joint.residual_count = 5'(rb) + 5'(mb) + 5'd1;
		joint.magnitude_clipped = (mag_ext > MW'(rmct_pkg::MAG_CLIP_ABOVE));
		joint.last = 1'b1;

		// zero run: split at 256, flush at row end
		r1 = {1'b0, zero_run} + 9'd1;
		long_run = r1[rmct_pkg::RUN_W];
		r2 = long_run ? 8'd1 : r1[rmct_pkg::RUN_W-1:0];
		long_tok = rmct_pkg::run_only_token(rmct_pkg::RUN_SPLIT_LEN);
		flush_tok = rmct_pkg::run_only_token(r2);
		flush_tok.last = 1'b1;

		pair.n = 2'd0;
		pair.tok0 = joint;
		pair.tok1 = flush_tok;
		if (!is_zero) begin
			pair.n = 2'd1;
		end else begin
			case ({long_run, row_end})
				2'b10: begin
					pair.n = 2'd1;
					pair.tok0 = long_tok;
					pair.tok0.last = 1'b1;
				end
				2'b01: begin
					pair.n = 2'd1;
					pair.tok0 = flush_tok;
				end
				2'b11: begin
					pair.n = 2'd2;
					pair.tok0 = long_tok;
				end
				default: begin
					pair.n = 2'd0;
				end
			endcase
		end

		if (is_zero && !row_end) begin
			zero_run_next = r2;
		end else begin
			zero_run_next = '0;
		end
	end

endmodule
`default_nettype wire

// ----- sv/rmct_out_buf.sv -----
`default_nettype none
module rmct_out_buf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire rmct_pkg::tok_pair_t pair,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output rmct_pkg::token_t         tok,
	output logic                     can_take
);

	logic             out_v_q;
	logic             pend_v_q;
	rmct_pkg::token_t out_q;
	rmct_pkg::token_t pend_q;
	logic             fill;

	assign can_take = !pend_v_q && (!out_v_q || out_ready);
	assign fill = load && (pair.n != 2'd0);
	assign out_valid = out_v_q;
	assign tok = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (pend_v_q && out_ready) begin
			out_v_q <= 1'b1;
			pend_v_q <= 1'b0;
		end else if (fill) begin
			out_v_q <= 1'b1;
			pend_v_q <= (pair.n == 2'd2);
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_v_q && out_ready) begin
			out_q <= pend_q;
		end else if (fill) begin
			out_q <= pair.tok0;
			pend_q <= pair.tok1;
		end
	end

endmodule
`default_nettype wire

// ----- sv/run_magnitude_class_tokenizer_top.sv -----
// channel | signals                                   | dir
// input   | in_valid in_ready coefficient row_end     | in
// output  | out_valid out_ready symbol residual_value | out
//         | residual_count magnitude_clipped last     |
//
// an item is registered on accept in the input register and its tokens then
// reach the output register; one item per cycle when each item makes at most one
// token and out_ready stays high; an item making two tokens holds the next item
// in the input register while the second token waits in the holding register
// reset clears the valid flags and the zero run count
// out_ready low holds the token; in_ready drops while a full input register
// cannot move on
`default_nettype none
module run_magnitude_class_tokenizer_top #(
	parameter int COEFF_WIDTH = rmct_pkg::COEFF_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [COEFF_WIDTH-1:0]        coefficient,
	input  wire logic                          row_end,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [rmct_pkg::SYM_W-1:0]         symbol,
	output logic [rmct_pkg::RES_W-1:0]         residual_value,
	output logic [rmct_pkg::CNT_W-1:0]         residual_count,
	output logic                               magnitude_clipped,
	output logic                               last
);

	logic                       valid_s1;
	logic [COEFF_WIDTH-1:0]     coeff_s1;
	logic                       row_end_s1;
	logic [rmct_pkg::RUN_W-1:0] zero_run_q;
	logic [rmct_pkg::RUN_W-1:0] zero_run_next;
	rmct_pkg::tok_pair_t        pair;
	rmct_pkg::token_t           tok;
	logic                       can_take;
	logic                       advance;

	assign advance = valid_s1 && ((pair.n == 2'd0) || can_take);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			zero_run_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				zero_run_q <= zero_run_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			coeff_s1 <= coefficient;
			row_end_s1 <= row_end;
		end
	end

	rmct_encode #(
		.COEFF_WIDTH(COEFF_WIDTH)
	) u_encode (
		.coefficient  (coeff_s1),
		.row_end      (row_end_s1),
		.zero_run     (zero_run_q),
		.pair         (pair),
		.zero_run_next(zero_run_next)
	);

	rmct_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.pair     (pair),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.tok      (tok),
		.can_take (can_take)
	);

	assign symbol = tok.symbol;
	assign residual_value = tok.residual_value;
	assign residual_count = tok.residual_count;
	assign magnitude_clipped = tok.magnitude_clipped;
	assign last = tok.last;

endmodule
`default_nettype wire

// ----- sv/rmct_checker.sv -----
`default_nettype none
module rmct_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [rmct_pkg::SYM_W-1:0]    symbol,
	input wire logic [rmct_pkg::RES_W-1:0]    residual_value,
	input wire logic [rmct_pkg::CNT_W-1:0]    residual_count,
	input wire logic                          magnitude_clipped
);

	// a held item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item dropped while stalled");

	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (symbol <= 8'd159) && (residual_count <= 5'd18))
		else $error("symbol or residual count out of range");

	a_resid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (residual_value >> residual_count) == '0)
		else $error("residual bits above count");

	a_run_only_unclipped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (symbol[3:0] == 4'd0) |-> !magnitude_clipped)
		else $error("clip flag on run-only token");

endmodule

bind run_magnitude_class_tokenizer_top rmct_checker u_rmct_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.symbol           (symbol),
	.residual_value   (residual_value),
	.residual_count   (residual_count),
	.magnitude_clipped(magnitude_clipped)
);
`default_nettype wire

// ----- tb/run_magnitude_class_tokenizer_top_test.sv -----
`timescale 1ns / 1ps
`default_nettype none
module run_magnitude_class_tokenizer_top_test;

	localparam int unsigned RUN_START [10] = '{0, 1, 2, 3, 4, 8, 16, 32, 64, 128};
	localparam int unsigned RUN_BITS [10] = '{0, 0, 0, 0, 2, 3, 4, 5, 6, 7};
	localparam int unsigned MAG_START [16] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 16, 32, 64,
		128, 256, 512, 1024};
	localparam int unsigned MAG_BITS [16] = '{0, 0, 0, 0, 0, 0, 0, 0, 3, 4, 5, 6, 7, 8,
		9, 10};
	localparam int unsigned ZERO_RUN_SPLIT = 255;
	localparam int unsigned ZERO_RUN_LIMIT = 256;
	localparam int unsigned MAG_CLIP_LIMIT = 2047;
	localparam int unsigned ITEMS_PER_PHASE = 434;
	localparam int unsigned DRAIN_CYCLES = 20;

	localparam logic [1:0] PH_RECV_SLOW = 2'd0;
	localparam logic [1:0] PH_SEND_SLOW = 2'd1;
	localparam logic [1:0] PH_FREE_RUN = 2'd2;

	typedef struct packed {
		logic signed [15:0] coef;
		logic               row_end;
		logic [1:0]         phase;
	} coef_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] coefficient = '0;
	logic row_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [rmct_pkg::SYM_W-1:0] symbol;
	logic [rmct_pkg::RES_W-1:0] residual_value;
	logic [rmct_pkg::CNT_W-1:0] residual_count;
	logic magnitude_clipped;
	logic last;

	coef_item_t pending_items [$];
	rmct_pkg::token_t expected_tokens [$];
	int unsigned zero_run_len = 0;
	logic [1:0] idle_phase = PH_RECV_SLOW;
	int unsigned mismatch_count = 0;
	int unsigned stim_count = 0;

	run_magnitude_class_tokenizer_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.coefficient      (coefficient),
		.row_end          (row_end),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.symbol           (symbol),
		.residual_value   (residual_value),
		.residual_count   (residual_count),
		.magnitude_clipped(magnitude_clipped),
		.last             (last)
	);

	always #5 clk = ~clk;

	function automatic int unsigned run_class_of(input int unsigned run);
		int unsigned c;
		c = 9;
		while (c > 0 && run < RUN_START[c]) c--;
		return c;
	endfunction

	function automatic int unsigned mag_class_of(input int unsigned mag);
		int unsigned c;
		c = 15;
		while (c > 0 && mag < MAG_START[c]) c--;
		return c;
	endfunction

	function automatic rmct_pkg::token_t run_length_token(input int unsigned run);
		rmct_pkg::token_t t;
		int unsigned rc;
		rc = run_class_of(run);
		t.symbol = 8'(rc * 16);
		t.residual_value = 18'((run - RUN_START[rc]) & ((32'd1 << RUN_BITS[rc]) - 1));
		t.residual_count = 5'(RUN_BITS[rc]);
		t.magnitude_clipped = 1'b0;
		t.last = 1'b0;
		return t;
	endfunction

	task automatic tokenize_coefficient(input logic signed [15:0] coef, input logic rend);
		rmct_pkg::token_t toks [2];
		int n;
		logic neg;
		int unsigned mag, rc, mc, rb, mb;
		logic [31:0] resid;
		n = 0;
		if (coef == 0) begin
			zero_run_len = (zero_run_len + 1) & 32'h1ff;
			if (zero_run_len >= ZERO_RUN_LIMIT) begin
				toks[n] = run_length_token(ZERO_RUN_SPLIT);
				n++;
				zero_run_len -= ZERO_RUN_SPLIT;
			end
			if (rend && zero_run_len > 0) begin
				toks[n] = run_length_token(zero_run_len);
				n++;
				zero_run_len = 0;
			end
		end else begin
			neg = coef[15];
			mag = neg ? 32'(-int'(coef)) : 32'(int'(coef));
			rc = run_class_of(zero_run_len);
			mc = mag_class_of(mag);
			rb = RUN_BITS[rc];
			mb = MAG_BITS[mc];
			resid = ((zero_run_len - RUN_START[rc]) & ((32'd1 << rb) - 1))
				| (((mag - MAG_START[mc]) & ((32'd1 << mb) - 1)) << rb)
				| (32'(neg) << (rb + mb));
			toks[0].symbol = 8'(rc * 16 + mc);
			toks[0].residual_value = 18'(resid);
			toks[0].residual_count = 5'(rb + mb + 1);
			toks[0].magnitude_clipped = (mag > MAG_CLIP_LIMIT);
			toks[0].last = 1'b0;
			n = 1;
			zero_run_len = 0;
		end
		for (int i = 0; i < n; i++) begin
			toks[i].last = (i == n - 1);
			expected_tokens.push_back(toks[i]);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		coef_item_t it;
		int unsigned send_idle;
		if (!arst_n) begin
			in_valid <= 1'b0;
			coefficient <= '0;
			row_end <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				tokenize_coefficient(coefficient, row_end);
			end
			send_idle = (idle_phase == PH_FREE_RUN) ? 0 :
				(idle_phase == PH_RECV_SLOW) ? 32 : 62;
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
				it = pending_items.pop_front();
				coefficient <= it.coef;
				row_end <= it.row_end;
				idle_phase <= it.phase;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		rmct_pkg::token_t want;
		int unsigned recv_idle;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_tokens.size() == 0) begin
					$error("token with no item pending: symbol %0d", symbol);
					mismatch_count++;
				end else begin
					want = expected_tokens.pop_front();
					if (symbol !== want.symbol) begin
						$error("symbol: expected %0d, got %0d", want.symbol, symbol);
						mismatch_count++;
					end
					if (residual_value !== want.residual_value) begin
						$error("residual_value: expected %0h, got %0h", want.residual_value,
							residual_value);
						mismatch_count++;
					end
					if (residual_count !== want.residual_count) begin
						$error("residual_count: expected %0d, got %0d", want.residual_count,
							residual_count);
						mismatch_count++;
					end
					if (magnitude_clipped !== want.magnitude_clipped) begin
						$error("magnitude_clipped: expected %0b, got %0b",
							want.magnitude_clipped, magnitude_clipped);
						mismatch_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						mismatch_count++;
					end
				end
			end
			recv_idle = (idle_phase == PH_FREE_RUN) ? 0 :
				(idle_phase == PH_RECV_SLOW) ? 62 : 32;
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic queue_coefficient(input logic signed [15:0] coef, input logic rend,
		input logic [1:0] phase);
		coef_item_t it;
		it.coef = coef;
		it.row_end = rend;
		it.phase = phase;
		pending_items.push_back(it);
		stim_count++;
	endtask

	function automatic logic signed [15:0] pick_nonzero();
		int unsigned cls, mag;
		logic signed [15:0] v;
		if ($urandom_range(9) == 0) begin
			v = 16'($urandom);
			return (v == 0) ? 16'sd1 : v;
		end
		cls = $urandom_range(15, 1);
		if (cls < 8) begin
			mag = cls;
		end else if (cls < 15) begin
			mag = $urandom_range((32'd1 << (cls - 5)) * 2 - 1, 32'd1 << (cls - 5));
		end else begin
			case ($urandom_range(3))
				0: mag = $urandom_range(2047, 1024);
				1: mag = $urandom_range(32767, 2048);
				2: return -16'sd32768;
				default: mag = $urandom_range(32767, 1024);
			endcase
		end
		return 16'($urandom_range(1) ? -int'(mag) : int'(mag));
	endfunction

	// a zero run of random length, then a nonzero value; rows end now and then
	task automatic queue_run_then_value(input logic [1:0] phase);
		int unsigned len, r;
		r = $urandom_range(99);
		if (r < 75) len = $urandom_range(3);
		else if (r < 93) len = $urandom_range(40, 4);
		else if (r < 98) len = $urandom_range(255, 41);
		else len = $urandom_range(520, 256);
		for (int i = 0; i < len; i++) begin
			queue_coefficient('0, ($urandom_range(99) < 2) ||
				(i == len - 1 && $urandom_range(99) < 10), phase);
		end
		queue_coefficient(pick_nonzero(), $urandom_range(99) < 15, phase);
	endtask

	initial begin
		// extremes and magnitude class edges
		queue_coefficient(16'sd0, 1'b1, PH_RECV_SLOW);
		queue_coefficient(16'sd1, 1'b0, PH_RECV_SLOW);
		queue_coefficient(-16'sd1, 1'b0, PH_RECV_SLOW);
		queue_coefficient(16'sd32767, 1'b0, PH_RECV_SLOW);
		queue_coefficient(-16'sd32768, 1'b0, PH_RECV_SLOW);
		queue_coefficient(16'sd2047, 1'b0, PH_RECV_SLOW);
		queue_coefficient(16'sd2048, 1'b0, PH_RECV_SLOW);
		queue_coefficient(-16'sd2048, 1'b0, PH_RECV_SLOW);
		queue_coefficient(16'sd1024, 1'b0, PH_RECV_SLOW);
		queue_coefficient(-16'sd1023, 1'b0, PH_RECV_SLOW);
		queue_coefficient(16'sd8, 1'b0, PH_RECV_SLOW);
		queue_coefficient(16'sd7, 1'b0, PH_RECV_SLOW);
		// run then a nonzero at row end
		queue_coefficient(16'sd0, 1'b0, PH_RECV_SLOW);
		queue_coefficient(16'sd0, 1'b0, PH_RECV_SLOW);
		queue_coefficient(16'sd0, 1'b0, PH_RECV_SLOW);
		queue_coefficient(16'sd0, 1'b0, PH_RECV_SLOW);
		queue_coefficient(16'sd16, 1'b1, PH_RECV_SLOW);
		// run left over at row end
		queue_coefficient(16'sd0, 1'b0, PH_RECV_SLOW);
		queue_coefficient(16'sd0, 1'b0, PH_RECV_SLOW);
		queue_coefficient(16'sd0, 1'b1, PH_RECV_SLOW);
		queue_coefficient(16'sh5555, 1'b0, PH_RECV_SLOW);
		queue_coefficient(16'shaaaa, 1'b1, PH_RECV_SLOW);
		stim_count = 0;
		for (int p = 0; p < 3; p++) begin
			while (stim_count < (p + 1) * ITEMS_PER_PHASE) begin
				queue_run_then_value(2'(p));
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || in_valid) @(posedge clk);
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_tokens.size() != 0) begin
			$error("%0d tokens never arrived", expected_tokens.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
